[rtl/spu_pkg.sv]
// Package for the solar position unit: constants and the arctangent table.
package spu_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int FractionBitsDefault = 15;
  localparam int TableLen = 24;

  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam longint GainQ30 = 64'd652032874;
  localparam longint DeclAmp = 64'd279650093;
  localparam longint Deg256Turn = 64'd92160;
  localparam int NightLow = -2048;
  localparam int NightHigh = 1536;
  localparam int ElevLimit = 23040;

  localparam logic [0:0] RegLatitude = 1'b0;
  localparam logic [0:0] RegNorthYaw = 1'b1;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;
      1: r = 32'h12E4051E;
      2: r = 32'h09FB385B;
      3: r = 32'h051111D4;
      4: r = 32'h028B0D43;
      5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;
      7: r = 32'h00517C55;
      8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

[rtl/spu_cordic_rot.sv]
// Pipelined rotation-mode CORDIC: binary angle in, cosine and sine in Q(F) out.
module spu_cordic_rot #(
  parameter int Stages = 16,
  parameter int Frac = 15
) (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         angle,
  output logic signed [Frac+2:0] cos_out,
  output logic signed [Frac+2:0] sin_out
);
  import spu_pkg::*;

  localparam int W = Frac + 3;
  localparam logic signed [W-1:0] Gain = W'(GainQ30 >>> (30 - Frac));

  logic signed [W-1:0] xs [Stages+1];
  logic signed [W-1:0] ys [Stages+1];
  logic signed [33:0]  zs [Stages+1];
  logic                fl [Stages+1];

  logic        flip_in;
  logic [31:0] a_in;

  assign flip_in = ((angle + QuarterTurn) & HalfTurn) != 32'd0;
  assign a_in = flip_in ? angle + HalfTurn : angle;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= Gain;
      ys[0] <= '0;
      zs[0] <= 34'(signed'(a_in));
      fl[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - 34'(atan_entry(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + 34'(atan_entry(i));
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  assign cos_out = fl[Stages] ? -xs[Stages] : xs[Stages];
  assign sin_out = fl[Stages] ? -ys[Stages] : ys[Stages];

endmodule

[rtl/spu_cordic_vec.sv]
// Pipelined vectoring-mode CORDIC: gain-scaled magnitude and binary angle.
module spu_cordic_vec #(
  parameter int Stages = 16,
  parameter int W = 20
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic signed [W-1:0] mag,
  output logic signed [33:0]  ang
);
  import spu_pkg::*;

  logic signed [W-1:0] xs [Stages+1];
  logic signed [W-1:0] ys [Stages+1];
  logic signed [33:0]  zs [Stages+1];

  always_comb begin
    xs[0] = x_in;
    ys[0] = y_in;
    zs[0] = '0;
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i][W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - 34'(atan_entry(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + 34'(atan_entry(i));
        end
      end
    end
  end

  assign mag = xs[Stages];
  assign ang = zs[Stages];

endmodule

[rtl/solar_position_unit.sv]
// Solar position unit top level: angle setup, CORDIC pipelines, combine and night factor.
// One beat enters per clock when the output is not stalled. Most of the pipeline depth comes
// from the four CORDIC pipelines in series (sine of the day angle, then the declination and
// hour sine/cosine pairs, then two vectoring passes). A stall freezes the whole pipeline, so
// nothing is lost or repeated; the last register stage is the output register.
module solar_position_unit #(
  parameter int CORDIC_STAGES = spu_pkg::CordicStagesDefault,
  parameter int FRACTION_BITS = spu_pkg::FractionBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [16:0]        hours,
  input  logic [8:0]         day_of_year,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  output logic signed [15:0] elevation,
  output logic [15:0]        night_factor
);
  import spu_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam int W = F + 3;
  localparam int VW = F + 5;
  localparam int Lat = 4 * CORDIC_STAGES + 12;
  localparam logic signed [W-1:0] Gain = W'(GainQ30 >>> (30 - F));

  logic signed [15:0] latitude;
  logic signed [16:0] north_yaw;
  logic en;
  logic [Lat-1:0] vld;

  assign en = !out_stall || !out_valid;
  assign in_stall = !en;
  assign out_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude <= '0;
      north_yaw <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegLatitude) latitude <= cfg_data[15:0];
      else north_yaw <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end

  // Stage 1: day and hour angles. Divisions by constants use compare-subtract and
  // reciprocal multiplication, exact over the whole input range.
  logic [31:0] day_ang, ha_ang;
  logic [16:0] hr1;
  logic [9:0]  dsum;
  logic [8:0]  dmod;
  logic [33:0] day_q;
  always_comb begin
    dsum = 10'd284 + 10'(day_of_year);
    if (dsum >= 10'd730) dmod = 9'(dsum - 10'd730);
    else if (dsum >= 10'd365) dmod = 9'(dsum - 10'd365);
    else dmod = dsum[8:0];
    // 2^32 = 365 * 11767033 + 251, and 23074430 = 251 * ceil(2^25 / 365).
    day_q = 34'(dmod) * 34'd11767033 + ((34'(dmod) * 34'd23074430) >> 25);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      day_ang <= day_q[31:0];
      hr1 <= hours;
    end
  end
  // hours*2^32/98304 = hours*2^17/3 = hours*43690 + floor(2*hours/3), where
  // 174763 = ceil(2^19 / 3).
  logic [35:0] ha_q;
  assign ha_q = 36'(hr1) * 36'd43690 + ((36'(hr1) * 36'd174763) >> 18);
  assign ha_ang = ha_q[31:0] + HalfTurn;

  logic signed [W-1:0] c0, s0;
  spu_cordic_rot #(.Stages(CORDIC_STAGES), .Frac(F)) u_day (
    .clk, .en, .angle(day_ang), .cos_out(c0), .sin_out(s0));

  // Hour angle travels alongside the day CORDIC.
  logic [31:0] ha_d [CORDIC_STAGES+1];
  always_ff @(posedge clk) if (en) ha_d[0] <= ha_ang;
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_had
    always_ff @(posedge clk) if (en) ha_d[i+1] <= ha_d[i];
  end

  // Declination angle, registered.
  logic [31:0] dec_ang, ha2;
  always_ff @(posedge clk) begin
    if (en) begin
      dec_ang <= 32'((DeclAmp * 64'(s0)) >>> F);
      ha2 <= ha_d[CORDIC_STAGES];
    end
  end

  // Degrees in 1/256 units to a binary angle, truncated toward zero. Since
  // 92160 = 2^11 * 45 this is |v| * 2^21 / 45 = |v| * 46603 + floor(|v| * 17 / 45),
  // and 50704489 = 17 * ceil(2^27 / 45).
  function automatic logic [31:0] deg_to_turn(input logic signed [16:0] v);
    logic [16:0] m;
    logic [43:0] q;
    m = v[16] ? 17'(-v) : 17'(v);
    q = 44'(m) * 44'd46603 + ((44'(m) * 44'd50704489) >> 27);
    return v[16] ? 32'(-q) : q[31:0];
  endfunction

  logic [31:0] lat_ang, yaw_ang;
  assign lat_ang = deg_to_turn(17'(latitude));
  assign yaw_ang = deg_to_turn(north_yaw);

  logic signed [W-1:0] cd, sd, cl, sl, ch, sh, cy, sy;
  spu_cordic_rot #(.Stages(CORDIC_STAGES), .Frac(F)) u_dec (
    .clk, .en, .angle(dec_ang), .cos_out(cd), .sin_out(sd));
  spu_cordic_rot #(.Stages(CORDIC_STAGES), .Frac(F)) u_lat (
    .clk, .en, .angle(lat_ang), .cos_out(cl), .sin_out(sl));
  spu_cordic_rot #(.Stages(CORDIC_STAGES), .Frac(F)) u_ha (
    .clk, .en, .angle(ha2), .cos_out(ch), .sin_out(sh));
  spu_cordic_rot #(.Stages(CORDIC_STAGES), .Frac(F)) u_yaw (
    .clk, .en, .angle(yaw_ang), .cos_out(cy), .sin_out(sy));

  // Combine: products registered before each further product.
  logic signed [2*W-1:0] p_cdch, p_east, p_sdcl, p_sdsl;
  logic signed [W-1:0] cl3, sl3, cy3, sy3, cy4, sy4;
  always_ff @(posedge clk) begin
    if (en) begin
      p_cdch <= cd * ch;
      p_east <= -(cd * sh);
      p_sdcl <= sd * cl;
      p_sdsl <= sd * sl;
      cl3 <= cl; sl3 <= sl; cy3 <= cy; sy3 <= sy;
    end
  end

  logic signed [W-1:0] cdch;
  assign cdch = W'(p_cdch >>> F);
  logic signed [2*W+1:0] n4, u4, e4;
  always_ff @(posedge clk) begin
    if (en) begin
      n4 <= (2*W+2)'(p_sdcl) - (2*W+2)'(cdch) * (2*W+2)'(sl3);
      u4 <= (2*W+2)'(p_sdsl) + (2*W+2)'(cdch) * (2*W+2)'(cl3);
      e4 <= (2*W+2)'(p_east);
      cy4 <= cy3; sy4 <= sy3;
    end
  end

  logic signed [VW-1:0] north, east, up;
  assign north = VW'(n4 >>> F);
  assign east = VW'(e4 >>> F);
  assign up = VW'(u4 >>> F);

  logic signed [VW-1:0] north5, east5, up5, nabs5;
  logic signed [VW+W-1:0] p_ncy, p_esy, p_nsy, p_ecy;
  always_ff @(posedge clk) begin
    if (en) begin
      p_ncy <= north * cy4; p_esy <= east * sy4;
      p_nsy <= north * sy4; p_ecy <= east * cy4;
      up5 <= up;
      nabs5 <= north[VW-1] ? -north : north;
      east5 <= east;
    end
  end
  assign north5 = nabs5;

  logic signed [VW+W:0] nx6, ny6;
  always_ff @(posedge clk) begin
    if (en) begin
      nx6 <= (VW+W+1)'(p_ncy) - (VW+W+1)'(p_esy);
      ny6 <= (VW+W+1)'(p_nsy) + (VW+W+1)'(p_ecy);
    end
  end

  function automatic logic signed [15:0] to_q15(input logic signed [VW+W:0] v);
    logic signed [VW+W+16:0] t;
    t = (VW+W+17)'(v);
    if (F >= 15) t = t >>> (F - 15);
    else t = t <<< (15 - F);
    if (t > 32767) return 16'sh7FFF;
    if (t < -32768) return 16'sh8000;
    return 16'(t);
  endfunction

  // First vectoring pass: horizontal magnitude.
  logic signed [VW-1:0] mag1;
  logic signed [33:0]   ang1;
  spu_cordic_vec #(.Stages(CORDIC_STAGES), .W(VW)) u_vh (
    .clk, .en, .x_in(north5), .y_in(east5), .mag(mag1), .ang(ang1));

  // Delay up and the rotated pair alongside the vectoring passes.
  localparam int D2 = 2 * CORDIC_STAGES + 3;
  logic signed [VW-1:0] up_d [CORDIC_STAGES+1];
  logic signed [15:0] dx_d [D2+1];
  logic signed [15:0] dy_d [D2+1];
  logic signed [15:0] dz_d [CORDIC_STAGES+4];
  assign up_d[0] = up5;
  assign dx_d[0] = to_q15(nx6 >>> F);
  assign dy_d[0] = to_q15(ny6 >>> F);
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_upd
    always_ff @(posedge clk) if (en) up_d[i+1] <= up_d[i];
  end
  for (genvar i = 0; i < D2; i++) begin : g_dxy
    always_ff @(posedge clk) if (en) begin
      dx_d[i+1] <= dx_d[i];
      dy_d[i+1] <= dy_d[i];
    end
  end

  logic signed [2*VW-1:0] hm_p;
  logic signed [VW-1:0] up7;
  always_ff @(posedge clk) begin
    if (en) begin
      hm_p <= (2*VW)'(mag1) * (2*VW)'(Gain);
      up7 <= up_d[CORDIC_STAGES];
    end
  end
  logic signed [VW-1:0] hm;
  assign hm = VW'(hm_p >>> F);

  assign dz_d[0] = to_q15((VW+W+1)'(up7));
  for (genvar i = 0; i < CORDIC_STAGES + 3; i++) begin : g_dz
    always_ff @(posedge clk) if (en) dz_d[i+1] <= dz_d[i];
  end

  logic signed [VW-1:0] mag2;
  logic signed [33:0]   ang2;
  spu_cordic_vec #(.Stages(CORDIC_STAGES), .W(VW)) u_ve (
    .clk, .en, .x_in(hm), .y_in(up7), .mag(mag2), .ang(ang2));

  // Elevation in 1/256 degree, clamped, registered.
  logic signed [15:0] elev;
  logic signed [55:0] ep;
  logic signed [23:0] er;
  always_comb begin
    ep = 56'(ang2) * 56'sd92160 + 56'sh80000000;
    er = 24'(ep >>> 32);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (er > ElevLimit) elev <= 16'(ElevLimit);
      else if (er < -ElevLimit) elev <= 16'(-ElevLimit);
      else elev <= 16'(er);
    end
  end

  // Night factor: u, then cubic. u = floor(du * 64 / 7), with 299594 = ceil(2^21 / 7).
  logic signed [15:0] elev2;
  logic [15:0] u;
  logic [1:0] nsel;
  logic [11:0] du;
  logic [30:0] u_q;
  assign du = 12'(elev - 16'(NightLow));
  assign u_q = 31'(du) * 31'd299594;
  always_ff @(posedge clk) begin
    if (en) begin
      elev2 <= elev;
      u <= 16'(u_q >> 15);
      if (elev <= NightLow) nsel <= 2'd1;
      else if (elev >= NightHigh) nsel <= 2'd2;
      else nsel <= 2'd0;
    end
  end

  logic [31:0] uu;
  logic [17:0] cub;
  logic [15:0] elev3u;
  logic signed [15:0] elev3;
  logic [1:0] nsel3;
  always_ff @(posedge clk) begin
    if (en) begin
      uu <= 32'(u) * 32'(u);
      cub <= 18'(18'd98304 - {1'b0, u, 1'b0});
      elev3 <= elev2;
      nsel3 <= nsel;
    end
  end
  assign elev3u = elev3;

  logic [49:0] prod;
  assign prod = 50'(uu) * 50'(cub);
  always_ff @(posedge clk) begin
    if (en) begin
      dir_x <= dx_d[D2];
      dir_y <= dy_d[D2];
      dir_z <= dz_d[CORDIC_STAGES + 3];
      elevation <= elev3u;
      if (nsel3 == 2'd1) night_factor <= 16'h8000;
      else if (nsel3 == 2'd2) night_factor <= 16'h0000;
      else night_factor <= 16'(17'd32768 - 17'(prod >> 30));
    end
  end

endmodule

[rtl/spu_checker.sv]
// Port-level checker for the solar position unit, bound to the top level.
module spu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] dir_z,
  input logic signed [15:0] elevation,
  input logic [15:0]        night_factor
);
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(elevation) && $stable(dir_z))
    else $error("output moved");
  a_stall_pass: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("input stalled needlessly");
  a_elev_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> elevation <= 16'sd23040 && elevation >= -16'sd23040) else $error("elevation");
  a_night: assert property (@(posedge clk) disable iff (rst)
    out_valid && elevation >= 16'sd1536 |-> night_factor == 16'd0) else $error("night");
endmodule

bind solar_position_unit spu_checker u_spu_checker (.*);
